// ===== hdl/utf16_to_utf8_transcoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define U2U8_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define U2U8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Types, codes and constants shared by the transcoder modules.
// ----------------------------------------------------------------------------
package u2u8_pkg;

   localparam int COUNT_WIDTH   = 20;  // width of the per-string byte counter
   localparam int CAP_W         = 20;  // capacity register width
   localparam int BYTE_COUNT_W  = 20;  // byte_count field width
   localparam int CMP_W         = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = QUEUE_AW + 1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = {CAP_W{1'b1}};

   // Code unit ranges
   localparam logic [15:0] SURR_FIRST = 16'hD800;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] SURR_LAST  = 16'hDFFF;
   localparam logic [15:0] ENDIAN_MIN = 16'hFFFE;
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   // UTF-8 marker bits
   localparam logic [7:0] LEAD2_MARK = 8'hC0;
   localparam logic [7:0] LEAD3_MARK = 8'hE0;
   localparam logic [7:0] LEAD4_MARK = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_ENDIAN   = 2'd2,
      ST_INVALID  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_OUT_CAPACITY = 1'b0,
      CSR_COUNT_ONLY   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_type;

   typedef struct packed {
      logic                    is_byte;
      logic [7:0]              out_byte;
      logic [1:0]              status;
      logic [BYTE_COUNT_W-1:0] byte_count;
      logic                    last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [CAP_W-1:0] out_capacity;
      logic             count_only;
   } cfg_type;

   // One classified item: up to four bytes, then an optional status
   typedef struct packed {
      logic [2:0]              n_bytes;
      logic [3:0][7:0]         bytes;
      logic                    has_status;
      status_type              status;
      logic [BYTE_COUNT_W-1:0] byte_count;
   } job_type;

endpackage

// ===== hdl/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: front end
// Accepts code units, tracks surrogates and byte counts, and queues jobs.
// ----------------------------------------------------------------------------
module u2u8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  u2u8_pkg::req_type req_data,
   input  u2u8_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              q_push,
   output u2u8_pkg::job_type q_job
);
   import u2u8_pkg::*;

   logic                   high_pending_ff, high_pending_in;
   logic [9:0]             high_bits_ff, high_bits_in;
   logic [COUNT_WIDTH-1:0] bytes_done_ff, bytes_done_in;
   logic                   discarding_ff, discarding_in;

   logic [15:0]            wc;
   logic                   last;
   logic                   accept;
   logic [20:0]            cp;
   logic [2:0]             enc_n;
   logic [3:0][7:0]        enc_bytes;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [CMP_W-1:0]       need;
   logic                   over;
   logic [CMP_W-1:0]       cnt_wide;

   logic                   do_finish;
   logic                   do_emit;
   logic                   hold_high;
   status_type             fin_status;

   assign wc        = req_data.code_unit;
   assign last      = req_data.last_unit;
   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   assign cp = SUPP_BASE + {1'b0, high_bits_ff, wc[9:0]};

   always_comb begin
      enc_bytes = '0;
      if (high_pending_ff) begin
         enc_n        = 3'd4;
         enc_bytes[0] = LEAD4_MARK | {5'b0, cp[20:18]};
         enc_bytes[1] = CONT_MARK  | {2'b0, cp[17:12]};
         enc_bytes[2] = CONT_MARK  | {2'b0, cp[11:6]};
         enc_bytes[3] = CONT_MARK  | {2'b0, cp[5:0]};
      end else if (wc < ONE_BYTE_LIMIT) begin
         enc_n        = 3'd1;
         enc_bytes[0] = wc[7:0];
      end else if (wc < TWO_BYTE_LIMIT) begin
         enc_n        = 3'd2;
         enc_bytes[0] = LEAD2_MARK | {3'b0, wc[10:6]};
         enc_bytes[1] = CONT_MARK  | {2'b0, wc[5:0]};
      end else begin
         enc_n        = 3'd3;
         enc_bytes[0] = LEAD3_MARK | {4'b0, wc[15:12]};
         enc_bytes[1] = CONT_MARK  | {2'b0, wc[11:6]};
         enc_bytes[2] = CONT_MARK  | {2'b0, wc[5:0]};
      end
   end

   assign new_count = bytes_done_ff + COUNT_WIDTH'(enc_n);
   assign need      = CMP_W'(bytes_done_ff) + CMP_W'(enc_n);
   assign over      = ~cfg.count_only & (need > CMP_W'(cfg.out_capacity));

   // Classify the unit
   always_comb begin
      do_finish  = 1'b0;
      do_emit    = 1'b0;
      hold_high  = 1'b0;
      fin_status = ST_OK;
      if (high_pending_ff) begin
         if (wc < LOW_FIRST || wc > SURR_LAST) begin
            do_finish  = 1'b1;
            fin_status = ST_INVALID;
         end else if (over) begin
            do_finish  = 1'b1;
            fin_status = ST_OVERFLOW;
         end else begin
            do_emit   = 1'b1;
            do_finish = last;
         end
      end else if (wc == '0) begin
         do_finish = 1'b1;
      end else if (wc >= SURR_FIRST && wc <= SURR_LAST) begin
         if (wc >= LOW_FIRST || last) begin
            do_finish  = 1'b1;
            fin_status = ST_INVALID;
         end else begin
            hold_high = 1'b1;
         end
      end else if (wc >= ENDIAN_MIN) begin
         do_finish  = 1'b1;
         fin_status = ST_ENDIAN;
      end else if (over) begin
         do_finish  = 1'b1;
         fin_status = ST_OVERFLOW;
      end else begin
         do_emit   = 1'b1;
         do_finish = last;
      end
   end

   assign cnt_wide = do_emit ? CMP_W'(new_count) : CMP_W'(bytes_done_ff);

   always_comb begin
      q_job            = '0;
      q_job.n_bytes    = (do_emit && !cfg.count_only) ? enc_n : 3'd0;
      q_job.bytes      = enc_bytes;
      q_job.has_status = do_finish;
      q_job.status     = fin_status;
      q_job.byte_count = cnt_wide[BYTE_COUNT_W-1:0];
      q_push = accept & ~discarding_ff &
               (do_finish | (do_emit & ~cfg.count_only));
   end

   always_comb begin
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      bytes_done_in   = bytes_done_ff;
      discarding_in   = discarding_ff;
      if (accept) begin
         if (discarding_ff) begin
            if (last) begin
               discarding_in = 1'b0;
            end
         end else if (do_finish) begin
            high_pending_in = 1'b0;
            high_bits_in    = '0;
            bytes_done_in   = '0;
            discarding_in   = (fin_status != ST_OK) && !last;
         end else if (hold_high) begin
            high_pending_in = 1'b1;
            high_bits_in    = wc[9:0];
         end else if (do_emit) begin
            high_pending_in = 1'b0;
            high_bits_in    = '0;
            bytes_done_in   = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
         bytes_done_ff   <= '0;
         discarding_ff   <= 1'b0;
      end else begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
         bytes_done_ff   <= bytes_done_in;
         discarding_ff   <= discarding_in;
      end
   end

endmodule

// ===== hdl/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: job queue
// Small FIFO of classified jobs between the front end and the serializer.
// ----------------------------------------------------------------------------
module u2u8_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u2u8_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output u2u8_pkg::job_type head_job
);
   import u2u8_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: back end
// Walks each job's bytes and any status into the registered result channel.
// ----------------------------------------------------------------------------
module u2u8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  u2u8_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output u2u8_pkg::rsp_type rsp_data
);
   import u2u8_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] total;
   logic       is_final;
   logic       load;

   assign total    = head_job.n_bytes + {2'b0, head_job.has_status};
   assign is_final = (idx_ff + 3'd1 == total);
   assign load     = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign pop      = load & is_final;

   always_comb begin
      rsp_in             = '0;
      rsp_in.last_of_run = is_final;
      if (idx_ff < head_job.n_bytes) begin
         rsp_in.is_byte  = 1'b1;
         rsp_in.out_byte = head_job.bytes[idx_ff[1:0]];
      end else begin
         rsp_in.status     = head_job.status;
         rsp_in.byte_count = head_job.byte_count;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = is_final ? 3'd0 : idx_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/utf16_to_utf8_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder, top level
// Path: each unit's job is queued, then its results leave the result register.
// Throughput: one unit per cycle while the queue has room; each result takes one
// rsp beat; multi-byte units are paced by the rsp side, behind a 4-job queue.
// Reset: synchronous, clears string state and queue, capacity to all ones,
// count-only off. No clearing pass; ready the cycle after reset drops.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top (
   input  logic                        clock,
   input  logic                        reset,
   // code unit input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  u2u8_pkg::req_type           req_data,
   // result channel: byte beats followed by one status beat per string
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output u2u8_pkg::rsp_type           rsp_data,
   // register write port
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  u2u8_pkg::csr_index_type     csr_index,
   input  logic [u2u8_pkg::CAP_W-1:0]  csr_data
);
   import u2u8_pkg::*;

   logic [CAP_W-1:0] out_capacity_ff, out_capacity_in;
   logic             count_only_ff, count_only_in;
   cfg_type          cfg;

   logic             q_push;
   job_type          q_job;
   logic             q_full;
   logic             q_pop;
   logic             q_head_valid;
   job_type          q_head_job;

   // Register writes are always taken; write them only while the block idles.
   assign csr_ready = 1'b1;

   always_comb begin
      out_capacity_in = out_capacity_ff;
      count_only_in   = count_only_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OUT_CAPACITY: out_capacity_in = csr_data;
            CSR_COUNT_ONLY:   count_only_in   = csr_data[0];
            default:          out_capacity_in = out_capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_capacity_ff <= CAPACITY_RESET;
         count_only_ff   <= 1'b0;
      end else begin
         out_capacity_ff <= out_capacity_in;
         count_only_ff   <= count_only_in;
      end
   end

   assign cfg.out_capacity = out_capacity_ff;
   assign cfg.count_only   = count_only_ff;

   // Front end: classify each unit, advance surrogate and count state, and
   // queue a job only when the unit causes results.
   u2u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   // Queue: decouple the front, one unit per cycle if not full, from the back.
   u2u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // Back end: emit the bytes of the head job, then any status, one per beat.
   u2u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hdl/u2u8_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_top_defines.svh"

module u2u8_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input u2u8_pkg::rsp_type           rsp_data
);
   import u2u8_pkg::*;

   // A status beat always closes the run of its unit.
   `U2U8_ASSERT_SAME(a_status_closes_run, clock, reset,
      rsp_valid && !rsp_data.is_byte, rsp_data.last_of_run,
      "status beat without last_of_run")

   // Byte beats carry no status and no count.
   `U2U8_ASSERT_SAME(a_byte_fields_clear, clock, reset,
      rsp_valid && rsp_data.is_byte,
      rsp_data.status == ST_OK && rsp_data.byte_count == '0,
      "byte beat with status or count set")

   // A multi-byte lead is always followed by a continuation byte.
   `U2U8_ASSERT_SAME(a_lead_not_final, clock, reset,
      rsp_valid && rsp_data.is_byte && rsp_data.out_byte[7:6] == 2'b11,
      !rsp_data.last_of_run,
      "lead byte marked as final result")

   // A stalled result beat holds.
   `U2U8_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "stalled result beat changed")

endmodule

bind utf16_to_utf8_transcoder_top u2u8_checker u_checker (.*);

// ===== verif/utf8_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream checker
// Watches the code unit, result and register channels of the transcoder,
// predicts the byte and status beats of each accepted code unit, and compares
// every accepted result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  u2u8_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  u2u8_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  u2u8_pkg::csr_index_type     csr_index,
   input  logic [u2u8_pkg::CAP_W-1:0]  csr_data,
   output int                          mismatch_count,
   output int                          due_count
);
   import u2u8_pkg::*;

   // register copy
   logic [CAP_W-1:0]       cap_limit;
   logic                   count_mode;
   // string state
   logic                   high_held;
   logic [9:0]             high_part;
   logic [COUNT_WIDTH-1:0] str_bytes;
   logic                   skipping;

   rsp_type utf8_due[$];
   int      errors;

   assign mismatch_count = errors;
   assign due_count      = utf8_due.size();

   initial errors = 0;

   task automatic close_string(input status_type st, input logic last);
      rsp_type r;
      r = '0;
      r.status      = st;
      r.byte_count  = BYTE_COUNT_W'(str_bytes);
      r.last_of_run = 1'b1;
      utf8_due.push_back(r);
      high_held = 1'b0;
      high_part = '0;
      str_bytes = '0;
      skipping  = (st != ST_OK) && !last;
   endtask

   task automatic encode_unit(input req_type beat);
      logic [15:0] wc;
      logic        last;
      logic [20:0] cp;
      logic [7:0]  enc [4];
      int          n;
      rsp_type     r;
      wc   = beat.code_unit;
      last = beat.last_unit;
      n    = 0;
      if (skipping) begin
         if (last) skipping = 1'b0;
         return;
      end
      if (high_held) begin
         if (wc < LOW_FIRST || wc > SURR_LAST) begin
            close_string(ST_INVALID, last);
            return;
         end
         cp = SUPP_BASE + {1'b0, high_part, wc[9:0]};
         high_held = 1'b0;
         high_part = '0;
         n = 4;
         enc[0] = LEAD4_MARK | {5'b0, cp[20:18]};
         enc[1] = CONT_MARK | {2'b0, cp[17:12]};
         enc[2] = CONT_MARK | {2'b0, cp[11:6]};
         enc[3] = CONT_MARK | {2'b0, cp[5:0]};
      end else if (wc == 16'h0000) begin
         close_string(ST_OK, last);
         return;
      end else if (wc >= SURR_FIRST && wc <= SURR_LAST) begin
         if (wc >= LOW_FIRST || last) begin
            close_string(ST_INVALID, last);
         end else begin
            high_held = 1'b1;
            high_part = wc[9:0];
         end
         return;
      end else if (wc >= ENDIAN_MIN) begin
         close_string(ST_ENDIAN, last);
         return;
      end else if (wc < ONE_BYTE_LIMIT) begin
         n = 1;
         enc[0] = wc[7:0];
      end else if (wc < TWO_BYTE_LIMIT) begin
         n = 2;
         enc[0] = LEAD2_MARK | {3'b0, wc[10:6]};
         enc[1] = CONT_MARK | {2'b0, wc[5:0]};
      end else begin
         n = 3;
         enc[0] = LEAD3_MARK | {4'b0, wc[15:12]};
         enc[1] = CONT_MARK | {2'b0, wc[11:6]};
         enc[2] = CONT_MARK | {2'b0, wc[5:0]};
      end

      if (!count_mode) begin
         if ({1'b0, str_bytes} + 21'(n) > {1'b0, cap_limit}) begin
            close_string(ST_OVERFLOW, last);
            return;
         end
         for (int i = 0; i < n; i++) begin
            r = '0;
            r.is_byte     = 1'b1;
            r.out_byte    = enc[i];
            r.last_of_run = !last && (i == n - 1);
            utf8_due.push_back(r);
         end
      end
      str_bytes = str_bytes + COUNT_WIDTH'(n);
      if (last) close_string(ST_OK, last);
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (utf8_due.size() == 0) begin
         $error("result beat with nothing predicted: %h", got);
         errors++;
         return;
      end
      want = utf8_due.pop_front();
      if (got.is_byte !== want.is_byte) begin
         $error("is_byte: expected %0h, actual %0h", want.is_byte, got.is_byte);
         errors++;
      end
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
         errors++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0h, actual %0h", want.status, got.status);
         errors++;
      end
      if (got.byte_count !== want.byte_count) begin
         $error("byte_count: expected %0h, actual %0h", want.byte_count, got.byte_count);
         errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %0h, actual %0h", want.last_of_run,
                got.last_of_run);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cap_limit  = CAPACITY_RESET;
         count_mode = 1'b0;
         high_held  = 1'b0;
         high_part  = '0;
         str_bytes  = '0;
         skipping   = 1'b0;
         utf8_due.delete();
      end else begin
         // compare first: a result never belongs to a unit of the same edge
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
         if (req_valid && !req_stall) encode_unit(req_data);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_OUT_CAPACITY) cap_limit = csr_data;
            else count_mode = csr_data[0];
         end
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder testbench
// Drives directed and random UTF-16 strings through the transcoder under
// several capacity and count-only settings, with random idling on both sides
// and one long receiver hold-off; a checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
   import u2u8_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {PT_ASCII, PT_TWO, PT_THREE, PT_PAIR} point_kind;
   typedef enum int {
      DF_LONE_LOW, DF_BROKEN_PAIR, DF_ENDIAN, DF_ZERO, DF_HIGH_AT_END
   } defect_kind;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_index_type     csr_index = CSR_OUT_CAPACITY;
   logic [CAP_W-1:0]  csr_data  = '0;

   int mismatch_count;
   int due_count;

   // knobs written by the main process only
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks     = 0;
   int units_sent    = 0;

   logic [15:0] text_units[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   utf16_to_utf8_transcoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   utf8_stream_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .due_count      (due_count)
   );

   // Offer one code unit beat. Called at a falling edge; returns at the falling
   // edge after the beat was taken, with valid still high so that the next
   // call can keep it up without a gap.
   task automatic send_unit(input logic [15:0] unit, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{code_unit: unit, last_unit: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      units_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait until every predicted beat has come out, then let the
   // pipeline run dry before touching the registers.
   task automatic settle();
      req_valid <= 1'b0;
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register; leaves csr_valid high, the caller drops it.
   task automatic write_reg(input csr_index_type idx, input logic [CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [CAP_W-1:0] cap, input logic only_count);
      write_reg(CSR_OUT_CAPACITY, cap);
      write_reg(CSR_COUNT_ONLY, {{(CAP_W-1){1'b0}}, only_count});
      csr_valid <= 1'b0;
   endtask

   task automatic add_code_point(input point_kind kind);
      case (kind)
         PT_ASCII: begin
            text_units.push_back(16'($urandom_range(16'h0001, 16'h007f)));
         end
         PT_TWO: begin
            text_units.push_back(16'($urandom_range(16'h0080, 16'h07ff)));
         end
         PT_THREE: begin
            if ($urandom_range(1))
               text_units.push_back(16'($urandom_range(16'h0800, 16'hd7ff)));
            else
               text_units.push_back(16'($urandom_range(16'he000, 16'hfffd)));
         end
         default: begin
            text_units.push_back(16'($urandom_range(16'hd800, 16'hdbff)));
            text_units.push_back(16'($urandom_range(16'hdc00, 16'hdfff)));
         end
      endcase
   endtask

   task automatic add_defect(input defect_kind kind);
      case (kind)
         DF_LONE_LOW: text_units.push_back(16'($urandom_range(16'hdc00, 16'hdfff)));
         DF_BROKEN_PAIR: begin
            text_units.push_back(16'($urandom_range(16'hd800, 16'hdbff)));
            text_units.push_back(16'($urandom_range(16'h0000, 16'hd7ff)));
         end
         DF_ENDIAN: text_units.push_back(16'($urandom_range(16'hfffe, 16'hffff)));
         DF_ZERO:   text_units.push_back(16'h0000);
         default:   text_units.push_back(16'($urandom_range(16'hd800, 16'hdbff)));
      endcase
   endtask

   // Send the staged units, flagging the final one when asked.
   task automatic send_text(input logic flag_end);
      int count;
      count = text_units.size();
      for (int i = 0; i < count; i++)
         send_unit(text_units[i], flag_end && (i == count - 1));
      text_units.delete();
   endtask

   // Mostly well-formed strings with random content; the rest carry one
   // defect or are plain noise with random last flags.
   task automatic send_random_string();
      int pick;
      int points;
      pick   = $urandom_range(99);
      points = $urandom_range(1, 5);
      if (pick < 75) begin
         repeat (points) add_code_point(point_kind'($urandom_range(3)));
         send_text(1'b1);
      end else if (pick < 92) begin
         repeat (points) add_code_point(point_kind'($urandom_range(3)));
         add_defect(defect_kind'($urandom_range(4)));
         // an unflagged end runs on into the next string
         send_text(1'($urandom_range(3) != 0));
      end else begin
         repeat (points) send_unit(16'($urandom_range(16'hffff)), 1'($urandom_range(1)));
      end
   endtask

   // One register setting with a stretch of random strings; close any open
   // string with a flagged zero so the block ends up idle.
   task automatic run_phase(input logic [CAP_W-1:0] cap, input logic only_count,
                            input int units, input logic squeeze);
      int goal;
      settle();
      set_regs(cap, only_count);
      goal = units_sent + units;
      if (squeeze) begin
         // hold the receiver off and keep feeding wide characters so the
         // queue fills and the input stalls
         hold_asks++;
         repeat (10) add_code_point(point_kind'($urandom_range(PT_THREE, PT_PAIR)));
         send_text(1'b1);
      end
      while (units_sent < goal) send_random_string();
      send_unit(16'h0000, 1'b1);
   endtask

   task automatic run_directed();
      // zero unit ends the string
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0000, 1'b0);
      // boundaries of each encoded length
      send_unit(16'h007f, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07ff, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hfffd, 1'b1);
      // lowest and highest surrogate pairs
      send_unit(16'hd800, 1'b0);
      send_unit(16'hdc00, 1'b0);
      send_unit(16'hdbff, 1'b0);
      send_unit(16'hdfff, 1'b1);
      // lone low surrogate, then units dropped up to the last flag
      send_unit(16'hdc00, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0042, 1'b1);
      // high surrogate followed by something else
      send_unit(16'hd801, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0000, 1'b1);
      // high surrogate flagged last
      send_unit(16'hd900, 1'b1);
      // zero right after a high surrogate
      send_unit(16'hd800, 1'b0);
      send_unit(16'h0000, 1'b1);
      // byte order marks
      send_unit(16'hfffe, 1'b0);
      send_unit(16'hffff, 1'b1);
      send_unit(16'hffff, 1'b1);
      // overflow: second code point does not fit in three bytes
      settle();
      set_regs(20'd3, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'h0000, 1'b1);
   endtask

   // Receiver: random stalls, or a long hold-off counted here when asked.
   initial begin : rsp_side
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: a correct run ends far below this.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles lightly, receiver heavily
      send_idle_pct = 21;
      recv_idle_pct = 52;
      run_directed();
      run_phase(CAPACITY_RESET, 1'b0, 8, 1'b0);
      run_phase('0, 1'b0, 6, 1'b0);

      // the other way round
      send_idle_pct = 52;
      recv_idle_pct = 21;
      run_phase(CAP_W'($urandom_range(1, 16)), 1'b0, 8, 1'b0);
      run_phase(CAPACITY_RESET, 1'b1, 8, 1'b0);

      // no idling; one long hold-off on the receiver
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(CAPACITY_RESET, 1'b0, 8, 1'b1);
      run_phase(CAP_W'($urandom_range(20'hfffff)), 1'b1, 6, 1'b0);
      run_phase(CAP_W'($urandom_range(20'hfffff)), 1'b0, 6, 1'b0);

      settle();
      if (mismatch_count == 0 && due_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/u2u8_pkg.sv
hdl/u2u8_front.sv
hdl/u2u8_queue.sv
hdl/u2u8_back.sv
hdl/utf16_to_utf8_transcoder_top.sv
hdl/u2u8_checker.sv
verif/utf8_stream_checker.sv
verif/testbench.sv
